>>> src/owm_pkg.sv
// Shared types and constants for the one-wire master block.
package owm_pkg;

	localparam int NUM_CFG   = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = 16;

	localparam int FRONT_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF   = 2;

	// register indexes
	localparam logic [2:0] CFG_SETTLE      = 3'd0;
	localparam logic [2:0] CFG_RESET_LOW   = 3'd1;
	localparam logic [2:0] CFG_PRES_WAIT   = 3'd2;
	localparam logic [2:0] CFG_RESET_REC   = 3'd3;
	localparam logic [2:0] CFG_WRITE_LOW   = 3'd4;
	localparam logic [2:0] CFG_WRITE_DATA  = 3'd5;
	localparam logic [2:0] CFG_SLOT_GAP    = 3'd6;
	localparam logic [2:0] CFG_READ_SAMPLE = 3'd7;

	typedef logic [NUM_CFG-1:0][CFG_W-1:0] cfg_regs_t;

	localparam cfg_regs_t CFG_RESET_VAL = {16'd30, 16'd100, 16'd40, 16'd30,
		16'd1000, 16'd100, 16'd1000, 16'd44};

	// command kinds
	localparam logic [2:0] K_TICK  = 3'd0;
	localparam logic [2:0] K_RESET = 3'd1;
	localparam logic [2:0] K_WRITE = 3'd2;
	localparam logic [2:0] K_READ  = 3'd3;
	localparam logic [2:0] K_CONV  = 3'd4;
	localparam logic [2:0] K_TEMP  = 3'd5;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] data_byte;
		logic       line_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0] line_mode;
		logic       busy_res;
		logic       done_res;
		logic       status;
		logic [7:0] read_data;
		logic [7:0] temp_raw_low;
		logic [7:0] temp_raw_high;
		logic [7:0] temp_whole;
	} out_word_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data_byte;
		logic       line_in;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} front_q_t;

endpackage

>>> src/owm_cfg_regs.sv
// Timing configuration registers.
module owm_cfg_regs import owm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_regs_t            cfg
);

	localparam int IW = $clog2(NUM_CFG);

	cfg_regs_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET_VAL;
		end else if (cfg_valid && cfg_index < CFG_IDX_W'(NUM_CFG)) begin
			cfg_q[cfg_index[IW-1:0]] <= cfg_data;
		end
	end

endmodule

>>> src/owm_front.sv
// Input side: classifies each word and queues it for the sequencer.
module owm_front import owm_pkg::*; #(
	parameter int DEPTH = FRONT_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_word_t item,
	input  logic     take,
	output front_q_t fq
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;
	op_t           op_in;

	always_comb begin
		op_in.data_byte = item.data_byte;
		op_in.line_in   = item.line_in;
		if (item.action >= K_RESET && item.action <= K_TEMP) begin
			op_in.kind = item.action;
		end else begin
			op_in.kind = K_TICK;
		end
	end

	assign full    = (cnt_q == CW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = take && (cnt_q != '0);

	assign fq.valid = (cnt_q != '0);
	assign fq.op    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/owm_back.sv
// Bus sequencer: one tick per word, results queued for the consumer.
module owm_back import owm_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  front_q_t  fq,
	output logic      take,
	input  cfg_regs_t cfg,
	output logic      empty,
	input  logic      pop,
	output out_word_t result
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [3:0] PH_IDLE      = 4'd0;
	localparam logic [3:0] PH_IDLE_HIGH = 4'd1;
	localparam logic [3:0] PH_SETTLE    = 4'd2;
	localparam logic [3:0] PH_RST_LOW   = 4'd3;
	localparam logic [3:0] PH_RST_WAIT  = 4'd4;
	localparam logic [3:0] PH_RST_REC   = 4'd5;
	localparam logic [3:0] PH_WR_LOW    = 4'd6;
	localparam logic [3:0] PH_WR_DATA   = 4'd7;
	localparam logic [3:0] PH_WR_GAP    = 4'd8;
	localparam logic [3:0] PH_RD_LOW    = 4'd9;
	localparam logic [3:0] PH_RD_WAIT   = 4'd10;
	localparam logic [3:0] PH_RD_GAP    = 4'd11;

	localparam logic [1:0] LM_REL  = 2'd0;
	localparam logic [1:0] LM_LOW  = 2'd1;
	localparam logic [1:0] LM_HIGH = 2'd2;

	localparam logic [7:0] CMD_SKIP_ROM = 8'hcc;
	localparam logic [7:0] CMD_CONVERT  = 8'h44;
	localparam logic [7:0] CMD_READ_SP  = 8'hbe;

	function automatic logic phase_busy(input logic [3:0] ph);
		phase_busy = (ph >= PH_SETTLE) && (ph <= PH_RD_GAP);
	endfunction

	function automatic logic [1:0] phase_mode(input logic [3:0] ph, input logic bit0);
		case (ph)
			PH_IDLE_HIGH, PH_SETTLE:           phase_mode = LM_HIGH;
			PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: phase_mode = LM_LOW;
			PH_WR_DATA:                        phase_mode = bit0 ? LM_REL : LM_LOW;
			default:                           phase_mode = LM_REL;
		endcase
	endfunction

	// sequencer state
	logic [3:0]  ph_q;
	logic [15:0] tc_q;
	logic [2:0]  bi_q, kind_q, step_q;
	logic [7:0]  sr_q, lo_q, hi_q;
	logic        pres_q;

	logic [3:0]  ph_d;
	logic [15:0] tc_d, len, cfg_val;
	logic [16:0] nxt;
	logic [2:0]  bi_d, kind_d, step_d, step_old;
	logic [7:0]  sr_d, lo_d, hi_d;
	logic        pres_d, adv, fin, fin_st;
	out_word_t   res;

	// result queue
	out_word_t     omem_q [DEPTH];
	logic [PW-1:0] owr_q, ord_q;
	logic [CW-1:0] ocnt_q;
	logic          do_pop;

	assign take   = fq.valid && (ocnt_q != CW'(DEPTH));
	assign do_pop = pop && !empty;
	assign empty  = (ocnt_q == '0);
	assign result = omem_q[ord_q];

	always_comb begin
		ph_d     = ph_q;
		tc_d     = tc_q;
		bi_d     = bi_q;
		kind_d   = kind_q;
		step_d   = step_q;
		sr_d     = sr_q;
		lo_d     = lo_q;
		hi_d     = hi_q;
		pres_d   = pres_q;
		adv      = 1'b0;
		fin      = 1'b0;
		fin_st   = 1'b0;
		step_old = '0;
		nxt      = '0;
		cfg_val  = '0;
		len      = '0;
		res      = '0;

		if (!phase_busy(ph_d) && fq.op.kind != K_TICK) begin
			kind_d = fq.op.kind;
			step_d = 3'd1;
			tc_d   = '0;
			case (fq.op.kind)
				K_WRITE: begin
					sr_d = fq.op.data_byte;
					bi_d = '0;
					ph_d = PH_WR_LOW;
				end
				K_READ: begin
					sr_d = '0;
					bi_d = '0;
					ph_d = PH_RD_LOW;
				end
				default: begin
					step_d = '0;
					ph_d   = PH_SETTLE;
				end
			endcase
		end
		if (!phase_busy(ph_d)) begin
			ph_d = (ph_d == PH_IDLE_HIGH) ? PH_IDLE_HIGH : PH_IDLE;
		end

		res.line_mode = phase_mode(ph_d, sr_d[0]);

		if (phase_busy(ph_d)) begin
			case (ph_d)
				PH_SETTLE:             cfg_val = cfg[CFG_SETTLE];
				PH_RST_LOW:            cfg_val = cfg[CFG_RESET_LOW];
				PH_RST_WAIT:           cfg_val = cfg[CFG_PRES_WAIT];
				PH_RST_REC:            cfg_val = cfg[CFG_RESET_REC];
				PH_WR_LOW:             cfg_val = cfg[CFG_WRITE_LOW];
				PH_WR_DATA:            cfg_val = cfg[CFG_WRITE_DATA];
				PH_WR_GAP, PH_RD_GAP:  cfg_val = cfg[CFG_SLOT_GAP];
				PH_RD_WAIT:            cfg_val = cfg[CFG_READ_SAMPLE];
				default:               cfg_val = 16'd1;
			endcase
			len = (cfg_val == '0) ? 16'd1 : cfg_val;
			nxt = {1'b0, tc_d} + 17'd1;
			if (nxt >= {1'b0, len}) begin
				tc_d = '0;
				case (ph_d)
					PH_SETTLE:  ph_d = PH_RST_LOW;
					PH_RST_LOW: ph_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						pres_d = !fq.op.line_in;
						ph_d   = PH_RST_REC;
					end
					PH_RST_REC: adv = 1'b1;
					PH_WR_LOW:  ph_d = PH_WR_DATA;
					PH_WR_DATA: ph_d = PH_WR_GAP;
					PH_WR_GAP: begin
						sr_d = {1'b0, sr_d[7:1]};
						if (bi_d == 3'd7) begin
							adv = 1'b1;
						end else begin
							bi_d = bi_d + 1'b1;
							ph_d = PH_WR_LOW;
						end
					end
					PH_RD_LOW: ph_d = PH_RD_WAIT;
					PH_RD_WAIT: begin
						sr_d = {fq.op.line_in, sr_d[7:1]};
						ph_d = PH_RD_GAP;
					end
					PH_RD_GAP: begin
						if (bi_d == 3'd7) begin
							adv = 1'b1;
						end else begin
							bi_d = bi_d + 1'b1;
							ph_d = PH_RD_LOW;
						end
					end
					default: ph_d = PH_IDLE;
				endcase

				if (adv) begin
					step_old = step_d;
					step_d   = step_d + 1'b1;
					case (kind_d)
						K_RESET: begin
							ph_d   = PH_IDLE;
							fin    = 1'b1;
							fin_st = !pres_d;
						end
						K_CONV: begin
							if (step_old == 3'd0 && !pres_d) begin
								ph_d   = PH_IDLE;
								fin    = 1'b1;
								fin_st = 1'b1;
							end else if (step_old == 3'd0 || step_old == 3'd1) begin
								sr_d = (step_old == 3'd0) ? CMD_SKIP_ROM : CMD_CONVERT;
								bi_d = '0;
								ph_d = PH_WR_LOW;
							end else begin
								ph_d = PH_IDLE_HIGH;
								fin  = 1'b1;
							end
						end
						K_TEMP: begin
							if (step_old == 3'd0 || step_old == 3'd1) begin
								sr_d = (step_old == 3'd0) ? CMD_SKIP_ROM : CMD_READ_SP;
								bi_d = '0;
								ph_d = PH_WR_LOW;
							end else if (step_old == 3'd2 || step_old == 3'd3) begin
								if (step_old == 3'd3) begin
									lo_d = sr_d;
								end
								sr_d = '0;
								bi_d = '0;
								ph_d = PH_RD_LOW;
							end else begin
								hi_d = sr_d;
								ph_d = PH_IDLE;
								fin  = 1'b1;
							end
						end
						default: begin
							ph_d = PH_IDLE;
							fin  = 1'b1;
						end
					endcase
				end
			end else begin
				tc_d = nxt[15:0];
			end
		end

		res.busy_res = phase_busy(ph_d);
		if (fin) begin
			res.done_res = 1'b1;
			if (kind_d == K_RESET || kind_d == K_CONV) begin
				res.status = fin_st;
			end
			if (kind_d == K_READ) begin
				res.read_data = sr_d;
			end
			if (kind_d == K_TEMP) begin
				res.temp_raw_low  = lo_d;
				res.temp_raw_high = hi_d;
				res.temp_whole    = {hi_d[3:0], lo_d[7:4]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			tc_q   <= '0;
			bi_q   <= '0;
			kind_q <= '0;
			step_q <= '0;
			sr_q   <= '0;
			lo_q   <= '0;
			hi_q   <= '0;
			pres_q <= 1'b0;
		end else if (take) begin
			ph_q   <= ph_d;
			tc_q   <= tc_d;
			bi_q   <= bi_d;
			kind_q <= kind_d;
			step_q <= step_d;
			sr_q   <= sr_d;
			lo_q   <= lo_d;
			hi_q   <= hi_d;
			pres_q <= pres_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			omem_q[owr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= '0;
			ord_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (take) begin
				owr_q <= (owr_q == PW'(DEPTH - 1)) ? '0 : owr_q + 1'b1;
			end
			if (do_pop) begin
				ord_q <= (ord_q == PW'(DEPTH - 1)) ? '0 : ord_q + 1'b1;
			end
			if (take && !do_pop) begin
				ocnt_q <= ocnt_q + 1'b1;
			end else if (do_pop && !take) begin
				ocnt_q <= ocnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/one_wire_master_temp_sensor.sv
// Top level of the one-wire bus master with temperature sequencer.
//
// Input channel: a word (action, data_byte, line_in) is taken at a clock edge
// with push high and full low. Each word is one bus timing unit; a command
// arriving while an operation runs acts as a plain tick.
// Result channel: one result word per input word, in order. The oldest word
// sits on result while empty is low and leaves on an edge with pop high.
// Configuration: cfg_valid/cfg_ready write the slot length register at
// cfg_index; cfg_ready is always high. Write only while the block is idle.
// Path: an input word is registered in the input queue, then one sequencer
// step writes its result word into the result queue, where it shows on
// result until popped.
// Throughput: one word and one sequencer tick per cycle when not stalled.
// Stall: if pop stays low the result queue fills, the sequencer holds, and
// full rises once the input queue fills too.
// Reset: both queues empty, sequencer idle, line released, registers at
// their default slot lengths.
module one_wire_master_temp_sensor import owm_pkg::*; #(
	parameter int FRONT_DEPTH = FRONT_DEPTH_DEF,
	parameter int OUT_DEPTH   = OUT_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  in_word_t             item,
	output logic                 empty,
	input  logic                 pop,
	output out_word_t            result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_regs_t cfg;
	front_q_t  fq;
	logic      take;

	owm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owm_front #(.DEPTH(FRONT_DEPTH)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.take   (take),
		.fq     (fq)
	);

	owm_back #(.DEPTH(OUT_DEPTH)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.fq     (fq),
		.take   (take),
		.cfg    (cfg),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule

>>> src/owm_checker.sv
// Port-level checks for the one-wire master, bound to the top level.
module owm_checker import owm_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      full,
	input logic      empty,
	input logic      pop,
	input out_word_t result
);

	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> empty && !full)
		else $error("queues not empty after reset");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result word changed while stalled");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.done_res |-> !result.busy_res)
		else $error("done word reports busy");

	a_temp_whole: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.temp_whole ==
			{result.temp_raw_high[3:0], result.temp_raw_low[7:4]})
		else $error("whole degrees do not match raw bytes");

endmodule

bind one_wire_master_temp_sensor owm_checker u_owm_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.full   (full),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

>>> test/one_wire_master_temp_sensor_test.sv
// Self-checking testbench for the one-wire master: directed table, random sequences, predictor.
module one_wire_master_temp_sensor_test;
	import owm_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE, ST_IDLE_HIGH, ST_SETTLE, ST_RST_LOW, ST_RST_WAIT, ST_RST_REC,
		ST_WR_LOW, ST_WR_DATA, ST_WR_GAP, ST_RD_LOW, ST_RD_WAIT, ST_RD_GAP
	} bus_phase_t;

	localparam logic [1:0] LINE_REL  = 2'd0;
	localparam logic [1:0] LINE_LOW  = 2'd1;
	localparam logic [1:0] LINE_HIGH = 2'd2;

	// line level fed on the ticks that follow a table row
	localparam logic [1:0] TAIL_NONE = 2'd0;
	localparam logic [1:0] TAIL_LOW  = 2'd1;
	localparam logic [1:0] TAIL_HIGH = 2'd2;
	localparam logic [1:0] TAIL_RAND = 2'd3;

	typedef struct packed {
		in_word_t   w;
		logic [1:0] tail;
		logic       typed;
		out_word_t  want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	in_word_t             item;
	logic                 empty;
	logic                 pop;
	out_word_t            result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	out_word_t pending_results[$];
	plan_row_t plan[$];
	int        mismatches   = 0;
	int        words_sent   = 0;
	int        words_popped = 0;
	int        ops_done     = 0;
	logic      push_burst   = 1'b0;
	logic      pop_burst    = 1'b0;

	cfg_regs_t  slot_len_cfg = CFG_RESET_VAL;
	bus_phase_t ow_phase     = ST_IDLE;
	logic [15:0] ow_ticks    = '0;
	logic [2:0]  ow_bit      = '0;
	logic [7:0]  ow_shift    = '0;
	logic [2:0]  ow_kind     = '0;
	logic [2:0]  ow_step     = '0;
	logic        ow_present  = 1'b0;
	logic [7:0]  ow_lo       = '0;
	logic [7:0]  ow_hi       = '0;
	logic        ow_fin      = 1'b0;
	logic        ow_fin_st   = 1'b0;

	one_wire_master_temp_sensor u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		#1000000;
		$display("simulation failed");
		$finish;
	end

	function automatic logic ow_busy();
		return ow_phase >= ST_SETTLE && ow_phase <= ST_RD_GAP;
	endfunction

	function automatic void begin_write(logic [7:0] b);
		ow_shift = b;
		ow_bit   = '0;
		ow_ticks = '0;
		ow_phase = ST_WR_LOW;
	endfunction

	function automatic void begin_read();
		ow_shift = '0;
		ow_bit   = '0;
		ow_ticks = '0;
		ow_phase = ST_RD_LOW;
	endfunction

	function automatic void end_op(bus_phase_t nxt, logic st);
		ow_phase  = nxt;
		ow_ticks  = '0;
		ow_fin    = 1'b1;
		ow_fin_st = st;
	endfunction

	// one reset, byte write or byte read of the sequence has finished
	function automatic void next_stage();
		logic [2:0] s;
		s = ow_step;
		ow_step = ow_step + 3'd1;
		case (ow_kind)
			K_RESET: end_op(ST_IDLE, !ow_present);
			K_CONV: begin
				if (s == 3'd0) begin
					if (!ow_present) end_op(ST_IDLE, 1'b1);
					else begin_write(8'hcc);
				end else if (s == 3'd1) begin
					begin_write(8'h44);
				end else begin
					end_op(ST_IDLE_HIGH, 1'b0);
				end
			end
			K_TEMP: begin
				if (s == 3'd0) begin_write(8'hcc);
				else if (s == 3'd1) begin_write(8'hbe);
				else if (s == 3'd2) begin_read();
				else if (s == 3'd3) begin
					ow_lo = ow_shift;
					begin_read();
				end else begin
					ow_hi = ow_shift;
					end_op(ST_IDLE, 1'b0);
				end
			end
			default: end_op(ST_IDLE, 1'b0);
		endcase
	endfunction

	function automatic out_word_t bus_step(in_word_t w);
		out_word_t   o;
		logic [1:0]  mode;
		logic [2:0]  kind;
		logic [15:0] len;
		logic [16:0] nxt;
		ow_fin    = 1'b0;
		ow_fin_st = 1'b0;
		kind      = K_TICK;
		if (!ow_busy() && w.action >= K_RESET && w.action <= K_TEMP) begin
			ow_kind = w.action;
			ow_step = 3'd1;
			if (w.action == K_WRITE) begin_write(w.data_byte);
			else if (w.action == K_READ) begin_read();
			else begin
				ow_step  = 3'd0;
				ow_phase = ST_SETTLE;
				ow_ticks = '0;
			end
		end
		if (!ow_busy() && ow_phase != ST_IDLE_HIGH) ow_phase = ST_IDLE;
		case (ow_phase)
			ST_IDLE_HIGH, ST_SETTLE: mode = LINE_HIGH;
			ST_RST_LOW, ST_WR_LOW, ST_RD_LOW: mode = LINE_LOW;
			ST_WR_DATA: mode = ow_shift[0] ? LINE_REL : LINE_LOW;
			default: mode = LINE_REL;
		endcase
		if (ow_busy()) begin
			case (ow_phase)
				ST_SETTLE:            len = slot_len_cfg[CFG_SETTLE];
				ST_RST_LOW:           len = slot_len_cfg[CFG_RESET_LOW];
				ST_RST_WAIT:          len = slot_len_cfg[CFG_PRES_WAIT];
				ST_RST_REC:           len = slot_len_cfg[CFG_RESET_REC];
				ST_WR_LOW:            len = slot_len_cfg[CFG_WRITE_LOW];
				ST_WR_DATA:           len = slot_len_cfg[CFG_WRITE_DATA];
				ST_WR_GAP, ST_RD_GAP: len = slot_len_cfg[CFG_SLOT_GAP];
				ST_RD_WAIT:           len = slot_len_cfg[CFG_READ_SAMPLE];
				default:              len = 16'd1;
			endcase
			if (len == 16'd0) len = 16'd1;
			nxt = {1'b0, ow_ticks} + 17'd1;
			if (nxt >= {1'b0, len}) begin
				ow_ticks = '0;
				case (ow_phase)
					ST_SETTLE:   ow_phase = ST_RST_LOW;
					ST_RST_LOW:  ow_phase = ST_RST_WAIT;
					ST_RST_WAIT: begin
						ow_present = !w.line_in;
						ow_phase   = ST_RST_REC;
					end
					ST_RST_REC:  next_stage();
					ST_WR_LOW:   ow_phase = ST_WR_DATA;
					ST_WR_DATA:  ow_phase = ST_WR_GAP;
					ST_WR_GAP: begin
						ow_shift = ow_shift >> 1;
						if (ow_bit == 3'd7) next_stage();
						else begin
							ow_bit   = ow_bit + 3'd1;
							ow_phase = ST_WR_LOW;
						end
					end
					ST_RD_LOW:   ow_phase = ST_RD_WAIT;
					ST_RD_WAIT: begin
						ow_shift = {w.line_in, ow_shift[7:1]};
						ow_phase = ST_RD_GAP;
					end
					ST_RD_GAP: begin
						if (ow_bit == 3'd7) next_stage();
						else begin
							ow_bit   = ow_bit + 3'd1;
							ow_phase = ST_RD_LOW;
						end
					end
					default: ow_phase = ST_IDLE;
				endcase
			end else begin
				ow_ticks = nxt[15:0];
			end
			if (ow_fin) kind = ow_kind;
		end
		o = '0;
		o.line_mode = mode;
		o.busy_res  = ow_busy();
		if (ow_fin) begin
			ops_done++;
			o.done_res = 1'b1;
			if (kind == K_RESET || kind == K_CONV) o.status = ow_fin_st;
			if (kind == K_READ) o.read_data = ow_shift;
			if (kind == K_TEMP) begin
				o.temp_raw_low  = ow_lo;
				o.temp_raw_high = ow_hi;
				o.temp_whole    = {ow_hi[3:0], ow_lo[7:4]};
			end
		end
		return o;
	endfunction

	function automatic plan_row_t plan_row(logic [2:0] action, logic [7:0] data, logic line,
		logic [1:0] tail, logic typed, logic [1:0] mode, logic busy);
		plan_row_t r;
		r = '0;
		r.w.action         = action;
		r.w.data_byte      = data;
		r.w.line_in        = line;
		r.tail             = tail;
		r.typed            = typed;
		r.want.line_mode   = mode;
		r.want.busy_res    = busy;
		return r;
	endfunction

	task automatic report_bad(string msg);
		mismatches++;
		if (mismatches <= 40) $display("mismatch at result word %0d: %s", words_popped, msg);
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want) report_bad($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic send_word(in_word_t w, logic typed, out_word_t want);
		int        gap;
		out_word_t pred;
		gap = push_burst ? 0 : $urandom_range(0, 3);
		if ($urandom_range(0, 39) == 0) push_burst = !push_burst;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		pred = bus_step(w);
		pending_results.push_back(typed ? want : pred);
		do @(posedge clk); while (full);
		words_sent++;
	endtask

	// clock ticks until the operation under way is over
	task automatic run_out(logic [1:0] tail, logic noisy);
		in_word_t t;
		while (ow_busy()) begin
			t.action = K_TICK;
			if (noisy && $urandom_range(0, 7) == 0) t.action = 3'($urandom_range(0, 7));
			t.data_byte = 8'($urandom);
			case (tail)
				TAIL_LOW:  t.line_in = 1'b0;
				TAIL_HIGH: t.line_in = 1'b1;
				default:   t.line_in = 1'($urandom);
			endcase
			send_word(t, 1'b0, '0);
		end
	endtask

	task automatic load_regs(cfg_regs_t v);
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     val;
		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		// out-of-range indexes go last so that an aliasing write would show
		for (int i = 0; i < NUM_CFG + 2; i++) begin
			if (i < NUM_CFG) begin
				idx = CFG_IDX_W'(i);
				val = v[i];
			end else begin
				idx = (i == NUM_CFG) ? 4'd8 : 4'd15;
				val = CFG_W'($urandom);
			end
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			do @(posedge clk); while (!cfg_ready);
			if (idx < NUM_CFG) slot_len_cfg[idx[2:0]] = val;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_ops(int n_items);
		in_word_t w;
		int       w0;
		int       r;
		w0 = words_sent;
		while (words_sent - w0 < n_items) begin
			r = $urandom_range(0, 11);
			w.data_byte = 8'($urandom);
			w.line_in   = 1'($urandom);
			if (r == 0) w.action = 3'($urandom_range(6, 7));
			else if (r == 1) w.action = K_TICK;
			else w.action = 3'($urandom_range(K_RESET, K_TEMP));
			send_word(w, 1'b0, '0);
			run_out(TAIL_RAND, 1'b1);
		end
	endtask

	initial begin
		out_word_t got;
		out_word_t want;
		int        gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = pop_burst ? 0 : $urandom_range(0, 3);
			if ($urandom_range(0, 39) == 0) pop_burst = !pop_burst;
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = result;
			words_popped++;
			if (pending_results.size() == 0) begin
				report_bad("result word with nothing expected");
			end else begin
				want = pending_results.pop_front();
				check_field("line_mode", 8'(got.line_mode), 8'(want.line_mode));
				check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
				check_field("done_res", 8'(got.done_res), 8'(want.done_res));
				check_field("status", 8'(got.status), 8'(want.status));
				check_field("read_data", got.read_data, want.read_data);
				check_field("temp_raw_low", got.temp_raw_low, want.temp_raw_low);
				check_field("temp_raw_high", got.temp_raw_high, want.temp_raw_high);
				check_field("temp_whole", got.temp_whole, want.temp_whole);
			end
		end
	end

	initial begin
		cfg_regs_t regs;
		arst_n    = 1'b0;
		push      = 1'b0;
		item      = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;

		plan.push_back(plan_row(K_TICK,  8'h00, 1'b0, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_TICK,  8'hff, 1'b1, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		plan.push_back(plan_row(3'd6,    8'h55, 1'b0, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		plan.push_back(plan_row(3'd7,    8'haa, 1'b1, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_RESET, 8'h00, 1'b0, TAIL_LOW,  1'b1, LINE_HIGH, 1'b1));
		plan.push_back(plan_row(K_RESET, 8'hff, 1'b1, TAIL_HIGH, 1'b1, LINE_HIGH, 1'b1));
		plan.push_back(plan_row(K_WRITE, 8'h00, 1'b0, TAIL_RAND, 1'b1, LINE_LOW,  1'b1));
		plan.push_back(plan_row(K_WRITE, 8'hff, 1'b1, TAIL_RAND, 1'b1, LINE_LOW,  1'b1));
		plan.push_back(plan_row(K_READ,  8'h00, 1'b1, TAIL_HIGH, 1'b1, LINE_LOW,  1'b1));
		plan.push_back(plan_row(K_READ,  8'hff, 1'b0, TAIL_LOW,  1'b0, LINE_REL,  1'b0));
		// conversion with no presence, then the bus is left released
		plan.push_back(plan_row(K_CONV,  8'h00, 1'b1, TAIL_HIGH, 1'b1, LINE_HIGH, 1'b1));
		plan.push_back(plan_row(K_TICK,  8'h00, 1'b1, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		// conversion with presence, then strong pull-up while idle
		plan.push_back(plan_row(K_CONV,  8'h3c, 1'b0, TAIL_LOW,  1'b0, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_TICK,  8'h00, 1'b0, TAIL_NONE, 1'b1, LINE_HIGH, 1'b0));
		plan.push_back(plan_row(3'd6,    8'hc3, 1'b1, TAIL_NONE, 1'b1, LINE_HIGH, 1'b0));
		// a command during read temperature is taken as a tick
		plan.push_back(plan_row(K_TEMP,  8'h00, 1'b1, TAIL_NONE, 1'b1, LINE_HIGH, 1'b1));
		plan.push_back(plan_row(K_WRITE, 8'h5a, 1'b1, TAIL_HIGH, 1'b0, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_TICK,  8'h00, 1'b0, TAIL_NONE, 1'b1, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_READ,  8'h00, 1'b0, TAIL_RAND, 1'b0, LINE_REL,  1'b0));
		plan.push_back(plan_row(K_WRITE, 8'h81, 1'b0, TAIL_RAND, 1'b0, LINE_REL,  1'b0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		regs = '0;
		load_regs(regs);

		for (int i = 0; i < plan.size(); i++) begin
			send_word(plan[i].w, plan[i].typed, plan[i].want);
			if (plan[i].tail != TAIL_NONE) run_out(plan[i].tail, 1'b0);
		end

		random_ops(40);

		for (int i = 0; i < NUM_CFG; i++) regs[i] = CFG_W'($urandom_range(1, 4));
		load_regs(regs);
		random_ops(60);

		push <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("%0d words sent, %0d result words checked, %0d bus operations finished",
			words_sent, words_popped, ops_done);
		$display("slot lengths run: all zero for the table and first random part, then short");
		if (mismatches == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
src/owm_pkg.sv
src/owm_cfg_regs.sv
src/owm_front.sv
src/owm_back.sv
src/one_wire_master_temp_sensor.sv
src/owm_checker.sv
test/one_wire_master_temp_sensor_test.sv
